// File: hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants shared by the first-fit block allocator files.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int BLOCK_COUNT = 4096;
  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(BLOCK_COUNT);
  localparam int RUN_W       = IDX_W + 1;

  localparam int SIZE_W      = 22;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int RSV_W       = 12;

  // Width of the block count of the largest request, after rounding up.
  localparam int NEED_W      = SIZE_W + 1 - BLOCK_SHIFT;

  // The map is kept as rows of 64 blocks, scanned in groups of 8.
  localparam int WORD_W      = 64;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROW_CNT     = BLOCK_COUNT / WORD_W;
  localparam int ROW_W       = $clog2(ROW_CNT);
  localparam int GROUP       = 8;
  localparam int GRP_W       = $clog2(GROUP);

  localparam logic [RSV_W-1:0]  RESERVED_RESET = 12'd16;
  localparam logic [ADDR_W-1:0] BASE_RESET     = 32'h0090_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_ZERO  = 3'd1,
    ST_OOM   = 3'd2,
    ST_RSRV  = 3'd3,
    ST_FREE  = 3'd4,
    ST_RANGE = 3'd5,
    ST_CHAIN = 3'd6
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic    capture;
    logic    init;
    logic    rd;
    logic    ld;
    logic    scan;
    logic    mark;
    logic    walk;
    logic    st_load;
    status_t st_code;
    logic    out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic    is_free;
    logic    zero;
    logic    range_err;
    logic    rsrv_err;
    logic    found;
    logic    grp_last;
    logic    pool_last;
    logic    mark_last;
    logic    walk_stop;
    status_t walk_code;
  } ctl_sts_t;

endpackage

// File: hdl/ffba_channels.sv
// ----------------------------------------------------------------------------
// ffba channels
// Request, response and configuration channels of the block allocator.
// ----------------------------------------------------------------------------
interface ffba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic [ffba_pkg::SIZE_W-1:0]   size_bytes;
  logic [ffba_pkg::ADDR_W-1:0]   address;

  modport source (output valid, cmd, size_bytes, address, input ready);
  modport sink   (input valid, cmd, size_bytes, address, output ready);
endinterface

interface ffba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffba_pkg::STATUS_W-1:0] status;
  logic [ffba_pkg::ADDR_W-1:0]   result_address;

  modport source (output valid, status, result_address, input ready);
  modport sink   (input valid, status, result_address, output ready);
endinterface

interface ffba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ffba_pkg::CFG_IDX_W-1:0]  index;
  logic [ffba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// First-fit allocator over a map of 4096 blocks of 512 bytes.
// ----------------------------------------------------------------------------
// Requests arrive on req: cmd selects allocate or free, size_bytes gives the
// allocate size and address the region to free. Each request yields one word
// on rsp carrying a status code and, for a successful allocate, the address.
// The cfg channel writes the reserved block count (index 0) and the pool base
// address (index 1); it is always ready. It must be written while no request is
// in flight; the block itself does not enforce this.
// The map is held in a 64-row RAM of 64 blocks per row. A request is set up in
// the capture and start states, and each row it touches is read in the read and
// load states. An allocate scans 8 blocks per cycle while a loaded row is in
// hand, and then marks each row of the run after reading it. A free walks
// 8 blocks per cycle from its index, pausing to read each new row, and a range
// or reserved error returns without reading the map. One request is in work at
// a time; the result passes through a status register into the output register.
// Reset frees every block at once through per-row valid bits, so no clearing
// pass is needed. While rsp is stalled the next request is still taken and
// processed; it then waits until the held word is taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_unit (
  input  logic       clk,
  input  logic       rst,
  ffba_req_if.sink   req,
  ffba_rsp_if.source rsp,
  ffba_cfg_if.sink   cfg
);

  ffba_pkg::ctl_cmd_t cmd;
  ffba_pkg::ctl_sts_t sts;

  assign cfg.ready = 1'b1;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  ffba_datapath u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg.valid),
    .cfg_index          (cfg.index),
    .cfg_data           (cfg.data),
    .req_cmd            (req.cmd),
    .req_size_bytes     (req.size_bytes),
    .req_address        (req.address),
    .rsp_status         (rsp.status),
    .rsp_result_address (rsp.result_address),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// File: hdl/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/ffba_datapath.sv
// ----------------------------------------------------------------------------
// ffba_datapath
// Block map storage, scan and walk logic, configuration and result registers.
// ----------------------------------------------------------------------------
module ffba_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            req_cmd,
  input  logic [ffba_pkg::SIZE_W-1:0]     req_size_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]     req_address,
  output logic [ffba_pkg::STATUS_W-1:0]   rsp_status,
  output logic [ffba_pkg::ADDR_W-1:0]     rsp_result_address,
  input  ffba_pkg::ctl_cmd_t              cmd,
  output ffba_pkg::ctl_sts_t              sts
);

  localparam int IDX_W  = ffba_pkg::IDX_W;
  localparam int BIT_W  = ffba_pkg::BIT_W;
  localparam int GRP_W  = ffba_pkg::GRP_W;
  localparam int WORD_W = ffba_pkg::WORD_W;
  localparam int SHIFT  = ffba_pkg::BLOCK_SHIFT;
  localparam int ADDR_W = ffba_pkg::ADDR_W;
  localparam int SIZE_SUM_W = ffba_pkg::SIZE_W + 1;

  logic [ffba_pkg::RSV_W-1:0]  reserved;
  logic [ADDR_W-1:0]           base;

  ffba_pkg::op_t               op_q;
  logic                        zero_q;
  logic                        range_q;
  logic [ffba_pkg::NEED_W-1:0] need_q;
  logic [IDX_W-1:0]            idx_q;

  logic [IDX_W-1:0]            pos;
  logic [IDX_W-1:0]            start_q;
  logic [IDX_W-1:0]            end_q;
  logic [ffba_pkg::RUN_W-1:0]  run;
  logic                        first;
  logic [WORD_W-1:0]           wused;
  logic [WORD_W-1:0]           wend;
  ffba_pkg::status_t           st_q;
  logic [ADDR_W-1:0]           addr_q;

  logic [ffba_pkg::ROW_CNT-1:0] row_valid;
  logic                         rd_valid;
  logic                         ram_we;
  logic [2*WORD_W-1:0]          ram_wdata;
  logic [2*WORD_W-1:0]          ram_rdata;
  logic [ffba_pkg::ROW_W-1:0]   row;

  logic [SIZE_SUM_W-1:0]        size_sum;
  logic [ADDR_W-1:0]            offset;

  // Scan results.
  logic [ffba_pkg::RUN_W-1:0]  scan_run;
  logic [IDX_W-1:0]            scan_start;
  logic                        scan_found;
  logic [IDX_W-1:0]            scan_end;

  // Walk results.
  logic [WORD_W-1:0]           walk_used;
  logic                        walk_stop;
  ffba_pkg::status_t           walk_code;

  // Mark results.
  logic [BIT_W-1:0]            mark_lo;
  logic [BIT_W-1:0]            mark_hi;
  logic                        mark_last;
  logic [WORD_W-1:0]           mark_used;
  logic [WORD_W-1:0]           mark_end;

  assign row      = pos[IDX_W-1:BIT_W];
  assign size_sum = {1'b0, req_size_bytes} + SIZE_SUM_W'(ffba_pkg::BLOCK_BYTES - 1);
  assign offset   = req_address - base;

  always_comb begin
    logic [IDX_W-1:0] q;
    scan_run   = run;
    scan_start = start_q;
    scan_found = 1'b0;
    scan_end   = end_q;
    for (int b = 0; b < ffba_pkg::GROUP; b++) begin
      q = {pos[IDX_W-1:GRP_W], GRP_W'(b)};
      if (!scan_found) begin
        if (q < reserved || wused[q[BIT_W-1:0]]) begin
          scan_run = '0;
        end else begin
          if (scan_run == '0) begin
            scan_start = q;
          end
          scan_run = scan_run + ffba_pkg::RUN_W'(1);
          if (ffba_pkg::NEED_W'(scan_run) >= need_q) begin
            scan_found = 1'b1;
            scan_end   = q;
          end
        end
      end
    end
  end

  // The free walk clears used bits from pos upward until it meets an end
  // mark or a block that is already free.
  always_comb begin
    logic [IDX_W-1:0] q;
    walk_used = wused;
    walk_stop = 1'b0;
    walk_code = ffba_pkg::ST_OK;
    for (int b = 0; b < ffba_pkg::GROUP; b++) begin
      q = {pos[IDX_W-1:GRP_W], GRP_W'(b)};
      if (!walk_stop && GRP_W'(b) >= pos[GRP_W-1:0]) begin
        if (!walk_used[q[BIT_W-1:0]]) begin
          walk_stop = 1'b1;
          walk_code = (first && GRP_W'(b) == pos[GRP_W-1:0]) ? ffba_pkg::ST_FREE
                                                              : ffba_pkg::ST_CHAIN;
        end else begin
          walk_used[q[BIT_W-1:0]] = 1'b0;
          if (wend[q[BIT_W-1:0]]) begin
            walk_stop = 1'b1;
            walk_code = ffba_pkg::ST_OK;
          end
        end
      end
    end
  end

  always_comb begin
    mark_lo   = (row == start_q[IDX_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
    mark_last = (row == end_q[IDX_W-1:BIT_W]);
    mark_hi   = mark_last ? end_q[BIT_W-1:0] : '1;
    mark_used = wused;
    mark_end  = wend;
    for (int b = 0; b < WORD_W; b++) begin
      if (BIT_W'(b) >= mark_lo && BIT_W'(b) <= mark_hi) begin
        mark_used[b] = 1'b1;
        mark_end[b]  = 1'b0;
      end
    end
    if (mark_last) begin
      mark_end[mark_hi] = 1'b1;
    end
  end

  assign ram_we    = cmd.mark || (cmd.walk && (walk_stop || sts.grp_last));
  assign ram_wdata = cmd.mark ? {mark_end, mark_used} : {wend, walk_used};

  ffba_ram #(
    .WIDTH (2 * WORD_W),
    .DEPTH (ffba_pkg::ROW_CNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (row),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (row),
    .rdata (ram_rdata)
  );

  // A row never written reads as all free with every end mark set.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      reserved  <= ffba_pkg::RESERVED_RESET;
      base      <= ffba_pkg::BASE_RESET;
    end else begin
      if (ram_we) begin
        row_valid[row] <= 1'b1;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          ffba_pkg::CFG_RESERVED: reserved <= cfg_data[ffba_pkg::RSV_W-1:0];
          ffba_pkg::CFG_BASE:     base     <= cfg_data[ADDR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_valid <= row_valid[row];
    end
    if (cmd.capture) begin
      op_q    <= ffba_pkg::op_t'(req_cmd);
      zero_q  <= (req_size_bytes == '0);
      need_q  <= size_sum[SIZE_SUM_W-1:SHIFT];
      range_q <= |offset[ADDR_W-1:SHIFT+IDX_W];
      idx_q   <= offset[SHIFT+IDX_W-1:SHIFT];
      addr_q  <= '0;
    end
    if (cmd.init) begin
      run   <= '0;
      first <= 1'b1;
      pos   <= (op_q == ffba_pkg::OP_FREE) ? idx_q : '0;
    end
    if (cmd.ld) begin
      wused <= rd_valid ? ram_rdata[WORD_W-1:0] : '0;
      wend  <= rd_valid ? ram_rdata[2*WORD_W-1:WORD_W] : '1;
    end
    if (cmd.scan) begin
      run     <= scan_run;
      start_q <= scan_start;
      if (scan_found) begin
        end_q <= scan_end;
        pos   <= scan_start;
      end else begin
        pos <= pos + IDX_W'(ffba_pkg::GROUP);
      end
    end
    if (cmd.mark) begin
      pos <= {row + ffba_pkg::ROW_W'(1), BIT_W'(0)};
      if (mark_last) begin
        addr_q <= base + (ADDR_W'(start_q) << SHIFT);
      end
    end
    if (cmd.walk) begin
      wused <= walk_used;
      first <= 1'b0;
      pos   <= {pos[IDX_W-1:GRP_W] + (IDX_W-GRP_W)'(1), GRP_W'(0)};
    end
    if (cmd.st_load) begin
      st_q <= cmd.st_code;
    end
    if (cmd.out_load) begin
      rsp_status         <= st_q;
      rsp_result_address <= addr_q;
    end
  end

  always_comb begin
    sts.is_free   = (op_q == ffba_pkg::OP_FREE);
    sts.zero      = zero_q;
    sts.range_err = range_q;
    sts.rsrv_err  = (idx_q < reserved);
    sts.found     = scan_found;
    sts.grp_last  = (pos[BIT_W-1:GRP_W] == '1);
    sts.pool_last = (pos[IDX_W-1:GRP_W] == '1);
    sts.mark_last = mark_last;
    sts.walk_stop = walk_stop;
    sts.walk_code = walk_code;
  end

  a_ld_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.ld |-> $past(cmd.rd))
    else $error("map word loaded without a read in the cycle before");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && cmd.rd))
    else $error("map read and write issued in the same cycle");

  a_mark_in_run: assert property (@(posedge clk) disable iff (rst)
    cmd.mark |-> (row >= start_q[IDX_W-1:BIT_W] && row <= end_q[IDX_W-1:BIT_W]))
    else $error("marking a row outside the allocated run");

endmodule

// File: hdl/ffba_ctrl.sv
// ----------------------------------------------------------------------------
// ffba_ctrl
// Request sequencer: steps the datapath through checks, scans and writes.
// ----------------------------------------------------------------------------
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ffba_pkg::ctl_cmd_t cmd,
  input  ffba_pkg::ctl_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_RD,
    S_LD,
    S_SCAN,
    S_MARK,
    S_WALK,
    S_RESP
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_START;
        end
      end
      S_START: begin
        cmd.init = 1'b1;
        if (sts.is_free) begin
          if (sts.range_err) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ffba_pkg::ST_RANGE;
            state_next  = S_RESP;
          end else if (sts.rsrv_err) begin
            cmd.st_load = 1'b1;
            cmd.st_code = ffba_pkg::ST_RSRV;
            state_next  = S_RESP;
          end else begin
            ret_next   = S_WALK;
            state_next = S_RD;
          end
        end else if (sts.zero) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffba_pkg::ST_ZERO;
          state_next  = S_RESP;
        end else begin
          ret_next   = S_SCAN;
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        cmd.ld     = 1'b1;
        state_next = ret;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.found) begin
          ret_next   = S_MARK;
          state_next = S_RD;
        end else if (sts.pool_last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffba_pkg::ST_OOM;
          state_next  = S_RESP;
        end else if (sts.grp_last) begin
          state_next = S_RD;
        end
      end
      S_MARK: begin
        cmd.mark = 1'b1;
        if (sts.mark_last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffba_pkg::ST_OK;
          state_next  = S_RESP;
        end else begin
          state_next = S_RD;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_stop) begin
          cmd.st_load = 1'b1;
          cmd.st_code = sts.walk_code;
          state_next  = S_RESP;
        end else if (sts.pool_last) begin
          cmd.st_load = 1'b1;
          cmd.st_code = ffba_pkg::ST_CHAIN;
          state_next  = S_RESP;
        end else if (sts.grp_last) begin
          state_next = S_RD;
        end
      end
      S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_SCAN;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_START))
    else $error("accepted request did not start processing");

  a_rsp_held: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("response word dropped while stalled");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || rsp_ready))
    else $error("response register overwritten while held");

endmodule

// File: sim/tb_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_channels
// Request and response records used by the testbench queues.
// ----------------------------------------------------------------------------
package tb_alloc_pkg;
  typedef struct {
    logic        cmd;
    logic [21:0] size_bytes;
    logic [31:0] address;
    int          gap;
  } alloc_req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] result_address;
  } alloc_rsp_t;
endpackage

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Block allocator check: directed and random allocate and free traffic against a map model.
// ----------------------------------------------------------------------------
// An initial block queues requests phase by phase. A clocked driver offers
// them with random gaps, and a clocked monitor takes responses with random
// stalls and compares each one with the oldest predicted response. Between
// phases the pool settings are rewritten while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int BLOCK_COUNT = ffba_pkg::BLOCK_COUNT;
  localparam int BLOCK_BYTES = ffba_pkg::BLOCK_BYTES;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffba_req_if req ();
  ffba_rsp_if rsp ();
  ffba_cfg_if cfg ();

  first_fit_block_allocator_unit dut (.clk(clk), .rst(rst), .req(req.sink),
                                      .rsp(rsp.source), .cfg(cfg.sink));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pool model.
  bit          used_bits [BLOCK_COUNT];
  bit          end_bits [BLOCK_COUNT];
  logic [11:0] rsv_count;
  logic [31:0] pool_base;
  // Live allocations, kept so frees mostly hit real run heads.
  logic [31:0] live_addrs [$];

  tb_alloc_pkg::alloc_req_t pending_reqs [$];
  tb_alloc_pkg::alloc_rsp_t expected_rsps [$];
  int  errors = 0;
  int  cycle_count = 0;
  bit  hold_rsp = 1'b0;
  int  long_hold = 0;

  function automatic tb_alloc_pkg::alloc_rsp_t predict_alloc(logic [21:0] size);
    tb_alloc_pkg::alloc_rsp_t r;
    int needed, run, start;
    r.status = ffba_pkg::ST_OK;
    r.result_address = '0;
    run = 0;
    start = 0;
    if (size == 0) begin
      r.status = ffba_pkg::ST_ZERO;
      return r;
    end
    needed = (int'(size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      if (i < rsv_count || used_bits[i]) begin
        run = 0;
      end else begin
        if (run == 0) start = i;
        run++;
        if (run >= needed) begin
          for (int j = start; j <= i; j++) begin
            used_bits[j] = 1'b1;
            end_bits[j] = 1'b0;
          end
          end_bits[i] = 1'b1;
          r.result_address = pool_base + 32'(start) * BLOCK_BYTES;
          live_addrs.push_back(r.result_address);
          return r;
        end
      end
    end
    r.status = ffba_pkg::ST_OOM;
    return r;
  endfunction

  function automatic logic [2:0] predict_free(logic [31:0] addr);
    logic [31:0] idx;
    idx = (addr - pool_base) / BLOCK_BYTES;
    if (idx >= BLOCK_COUNT) return ffba_pkg::ST_RANGE;
    if (idx < rsv_count) return ffba_pkg::ST_RSRV;
    if (!used_bits[idx]) return ffba_pkg::ST_FREE;
    for (int j = int'(idx); j < BLOCK_COUNT; j++) begin
      if (!used_bits[j]) return ffba_pkg::ST_CHAIN;
      used_bits[j] = 1'b0;
      if (end_bits[j]) return ffba_pkg::ST_OK;
    end
    return ffba_pkg::ST_CHAIN;
  endfunction

  task automatic queue_req(logic cmd, logic [21:0] size, logic [31:0] addr);
    tb_alloc_pkg::alloc_req_t q;
    tb_alloc_pkg::alloc_rsp_t r;
    q.cmd = cmd;
    q.size_bytes = size;
    q.address = addr;
    q.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (cmd == ffba_pkg::OP_ALLOC) begin
      r = predict_alloc(size);
    end else begin
      r.status = predict_free(addr);
      r.result_address = '0;
    end
    pending_reqs.push_back(q);
    expected_rsps.push_back(r);
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
    if (idx == ffba_pkg::CFG_RESERVED) rsv_count = value[11:0];
    else pool_base = value;
  endtask

  // Mostly small sizes, a few large, now and then a zero or a whole pool (2097152 bytes).
  function automatic logic [21:0] pick_size();
    case ($urandom_range(0, 19))
      0: return 22'd0;
      1: return 22'd2097152;
      2: return 22'($urandom_range(1, 22'h3FFFFF));
      3, 4: return 22'($urandom_range(1, 65536));
      default: return 22'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic random_phase(int count);
    int k;
    for (int n = 0; n < count; n++) begin
      if (live_addrs.size() != 0 && $urandom_range(0, 9) < 4) begin
        k = $urandom_range(0, live_addrs.size() - 1);
        queue_req(ffba_pkg::OP_FREE, 22'($urandom), live_addrs[k]);
        live_addrs.delete(k);
      end else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: queue_req(ffba_pkg::OP_FREE, 22'($urandom), $urandom);
          1: queue_req(ffba_pkg::OP_FREE, 22'($urandom),
                       pool_base + 32'($urandom_range(0, BLOCK_COUNT - 1)) * BLOCK_BYTES
                       + 32'($urandom_range(0, BLOCK_BYTES - 1)));
          default: queue_req(ffba_pkg::OP_FREE, 22'($urandom),
                             pool_base - 32'($urandom_range(1, 4096)));
        endcase
      end else begin
        queue_req(ffba_pkg::OP_ALLOC, pick_size(), $urandom);
      end
    end
  endtask

  // Driver.
  int drv_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req.ready) begin
    end else if (drv_wait > 0) begin
      req.valid <= 1'b0;
      drv_wait <= drv_wait - 1;
    end else if (pending_reqs.size() != 0 && !(req.valid && pending_reqs.size() == 0)) begin
      if (req.valid && req.ready) void'(pending_reqs.pop_front());
      if (req.valid && req.ready && pending_reqs.size() == 0) begin
        req.valid <= 1'b0;
      end else if (req.valid && req.ready && pending_reqs[0].gap != 0) begin
        req.valid <= 1'b0;
        drv_wait <= pending_reqs[0].gap - 1;
        pending_reqs[0].gap = 0;
      end else begin
        req.valid <= 1'b1;
        req.cmd <= pending_reqs[0].cmd;
        req.size_bytes <= pending_reqs[0].size_bytes;
        req.address <= pending_reqs[0].address;
      end
    end else begin
      req.valid <= 1'b0;
    end
  end

  // Long receiver stall, counted in cycles.
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 0;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end else if (hold_rsp) begin
      long_hold <= 400;
    end
  end

  // Monitor.
  int mon_wait = 0;
  always @(posedge clk) begin
    tb_alloc_pkg::alloc_rsp_t e;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t unexpected word: status %0d address %h", $time,
                   rsp.status, rsp.result_address);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status) begin
            $display("%0t status: expected %0d actual %0d", $time, e.status, rsp.status);
            errors++;
          end
          if (rsp.result_address !== e.result_address) begin
            $display("%0t address: expected %h actual %h", $time,
                     e.result_address, rsp.result_address);
            errors++;
          end
        end
      end
      if (long_hold > 0 || hold_rsp) begin
        rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
        mon_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        rsp.ready <= (mon_wait == 0);
      end else if (mon_wait > 0) begin
        mon_wait--;
        rsp.ready <= (mon_wait == 0);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
    if (cycle_count > 10000000) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = 1'b0;
    req.size_bytes = '0;
    req.address = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    rsv_count = ffba_pkg::RESERVED_RESET;
    pool_base = ffba_pkg::BASE_RESET;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      used_bits[i] = 1'b0;
      end_bits[i] = 1'b1;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset settings.
    queue_req(ffba_pkg::OP_ALLOC, 22'd0, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::OP_ALLOC, 22'd1, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd512, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd513, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'h3FFFFF, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd2097152, '0);
    queue_req(ffba_pkg::OP_FREE, 22'h3FFFFF, ffba_pkg::BASE_RESET + 32'd16 * 512 + 32'd17);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd16 * 512);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET - 1);
    queue_req(ffba_pkg::OP_FREE, '0, 32'hFFFF_FFFF);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd4095 * 512 + 32'd511);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd4096 * 512);
    queue_req(ffba_pkg::OP_ALLOC, 22'd1024, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd1024, '0);
    // Free the run at block 18 and then the one at block 17; both reach their end marks.
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd18 * 512);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd17 * 512);
    live_addrs.delete();
    wait_idle();

    // Reserved blocks grow over freed blocks, then the base moves near the top of the address space.
    write_reg(ffba_pkg::CFG_RESERVED, 32'd20);
    queue_req(ffba_pkg::OP_FREE, '0, ffba_pkg::BASE_RESET + 32'd19 * 512);
    queue_req(ffba_pkg::OP_ALLOC, 22'd1, '0);
    wait_idle();
    write_reg(ffba_pkg::CFG_RESERVED, 32'd0);
    write_reg(ffba_pkg::CFG_BASE, 32'hFFFF_FF00);
    queue_req(ffba_pkg::OP_ALLOC, 22'd1, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd2097152, '0);
    queue_req(ffba_pkg::OP_ALLOC, 22'd2097152 - 22'd512 * 22'd24, '0);
    queue_req(ffba_pkg::OP_FREE, '0, 32'hFFFF_FF00);
    wait_idle();

    // Stall the receiver long while requests keep coming.
    hold_rsp = 1'b1;
    random_phase(40);
    repeat (2) @(posedge clk);
    hold_rsp = 1'b0;
    wait_idle();

    write_reg(ffba_pkg::CFG_RESERVED, 32'd4095);
    write_reg(ffba_pkg::CFG_BASE, 32'd0);
    random_phase(60);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      write_reg(ffba_pkg::CFG_RESERVED, 32'($urandom_range(0, 300)));
      write_reg(ffba_pkg::CFG_BASE, (p == 4) ? 32'hFFFF_FFFF : $urandom);
      random_phase(200);
      wait_idle();
    end

    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// File: filelist.f
hdl/ffba_pkg.sv
hdl/ffba_channels.sv
hdl/ffba_ram.sv
hdl/ffba_datapath.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator_unit.sv
sim/tb_channels.sv
sim/tb_top.sv
